[rtl/core/ctm_pkg.sv]
// ----------------------------------------------------------------------------
// ctm_pkg: shared types and constants of the call timeout monitor
// Item layouts, request and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ctm_pkg;

    localparam int TIME_BITS     = 48;
    localparam int SLOT_BITS     = 4;
    localparam int CFG_BITS      = 32;
    localparam int DEFAULT_SLOTS = 16;

    localparam logic [CFG_BITS-1:0] MAX_CALL_RESET = 32'd1000;

    localparam logic [1:0] REQ_REGISTER = 2'd0;
    localparam logic [1:0] REQ_COMPLETE = 2'd1;
    localparam logic [1:0] REQ_QUERY    = 2'd2;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FULL       = 2'd1;
    localparam logic [1:0] STATUS_NOT_IN_USE = 2'd2;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [TIME_BITS-1:0] now_ms;
        logic [SLOT_BITS-1:0] slot_in;
        logic [TIME_BITS-1:0] since_ms;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0] slot_out;
        logic [1:0]           status;
        logic                 healthy;
        logic                 late;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic idx_clr;
        logic idx_inc;
        logic rd_en;
        logic rd_sel_slot;
        logic claim;
        logic full;
        logic bad_slot;
        logic complete;
        logic q_result;
        logic q_healthy;
        logic zero;
        logic push;
    } ctm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] req;
        logic       free_at_idx;
        logic       idx_last;
        logic       slot_ok;
        logic       seen_bad;
        logic       pend_over;
        logic       pend_last;
        logic       out_free;
    } ctm_stat_t;

endpackage

[rtl/core/call_timeout_health_monitor_unit.sv]
// ----------------------------------------------------------------------------
// call_timeout_health_monitor_unit: outstanding call timeout tracker
// Table of call start times with register, complete and health query.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A register item walks the busy bits
// one slot a cycle from slot 0 to the lowest free slot and claims it.
// A complete item reads its start time and then checks it; a slot not in
// use skips the read. A health query that a recorded late completion
// already decides needs no scan; otherwise the single read port of the
// start-time RAM is scanned one slot a cycle. A finished result waits
// in the output register while the next item is accepted. The start-time
// RAM needs no clearing pass after reset. max_call_ms can be written at
// any time the block is idle and is always ready.
module call_timeout_health_monitor_unit #(
    parameter int SLOTS = ctm_pkg::DEFAULT_SLOTS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  ctm_pkg::in_item_t            in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output ctm_pkg::out_item_t           out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ctm_pkg::CFG_BITS-1:0] cfg_data
);

    import ctm_pkg::*;

    ctm_cmd_t  cmd;
    ctm_stat_t stat;

    ctm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ctm_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

[rtl/core/ctm_ram.sv]
// ----------------------------------------------------------------------------
// ctm_ram: generic single write, single read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ctm_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/ctm_datapath.sv]
// ----------------------------------------------------------------------------
// ctm_datapath: slot table, limit register and result registers
// Holds the busy bits, the start-time RAM, the last late completion and
// the output register, and acts on commands from the controller.
// ----------------------------------------------------------------------------
module ctm_datapath #(
    parameter  int SLOTS = 16,
    localparam int IDXW  = $clog2(SLOTS)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ctm_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output ctm_pkg::out_item_t             out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ctm_pkg::CFG_BITS-1:0]   cfg_data,
    input  ctm_pkg::ctm_cmd_t              cmd,
    output ctm_pkg::ctm_stat_t             stat
);

    import ctm_pkg::*;

    in_item_t             item_reg,      item_next;
    logic [SLOTS-1:0]     busy_reg,      busy_next;
    logic [IDXW-1:0]      idx_reg,       idx_next;
    logic                 pend_reg,      pend_next;
    logic [IDXW-1:0]      pend_idx_reg,  pend_idx_next;
    logic                 seen_reg,      seen_next;
    logic [TIME_BITS-1:0] last_bad_reg,  last_bad_next;
    logic [CFG_BITS-1:0]  max_reg,       max_next;
    out_item_t            res_reg,       res_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg,  out_data_next;

    logic [IDXW-1:0]      slot_idx;
    logic                 in_range;
    logic [TIME_BITS-1:0] start_ms;
    logic [TIME_BITS-1:0] dur_ms;
    logic                 over;
    logic                 out_free;

    assign slot_idx = IDXW'(item_reg.slot_in);
    assign in_range = (32'(item_reg.slot_in) < SLOTS);
    assign dur_ms   = item_reg.now_ms - start_ms;
    assign over     = dur_ms > TIME_BITS'(max_reg);
    assign out_free = !out_valid_reg || !out_stall;

    ctm_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (SLOTS)
    ) u_start_ram (
        .clk     (clk),
        .wr_en   (cmd.claim),
        .wr_addr (idx_reg),
        .wr_data (item_reg.now_ms),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_sel_slot ? slot_idx : idx_reg),
        .rd_data (start_ms)
    );

    always_comb
    begin
        item_next      = item_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        seen_next      = seen_reg;
        last_bad_next  = last_bad_reg;
        max_next       = max_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cmd.load_item)
        begin
            item_next = in_data;
        end

        if (cmd.idx_clr)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
        end
        else
        begin
            if (cmd.rd_en && !cmd.rd_sel_slot)
            begin
                pend_next     = 1'b1;
                pend_idx_next = idx_reg;
            end
            if (cmd.idx_inc)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end

        if (cmd.claim)
        begin
            busy_next[idx_reg] = 1'b1;
            res_next = '{slot_out: SLOT_BITS'(idx_reg), status: STATUS_OK,
                         healthy: 1'b0, late: 1'b0};
        end
        else if (cmd.full)
        begin
            res_next = '{slot_out: '0, status: STATUS_FULL, healthy: 1'b0, late: 1'b0};
        end
        else if (cmd.bad_slot)
        begin
            res_next = '{slot_out: '0, status: STATUS_NOT_IN_USE,
                         healthy: 1'b0, late: 1'b0};
        end
        else if (cmd.complete)
        begin
            busy_next[slot_idx] = 1'b0;
            if (over)
            begin
                seen_next     = 1'b1;
                last_bad_next = item_reg.now_ms;
            end
            res_next = '{slot_out: '0, status: STATUS_OK, healthy: 1'b0, late: over};
        end
        else if (cmd.q_result)
        begin
            res_next = '{slot_out: '0, status: STATUS_OK, healthy: cmd.q_healthy,
                         late: 1'b0};
        end
        else if (cmd.zero)
        begin
            res_next = '0;
        end

        // hold the waiting result until taken
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            max_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            seen_reg      <= 1'b0;
            last_bad_reg  <= '0;
            max_reg       <= MAX_CALL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            seen_reg      <= seen_next;
            last_bad_reg  <= last_bad_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        pend_idx_reg <= pend_idx_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign stat.req         = item_reg.req_type;
    assign stat.free_at_idx = !busy_reg[idx_reg];
    assign stat.idx_last    = (idx_reg == IDXW'(SLOTS - 1));
    assign stat.slot_ok     = in_range && busy_reg[slot_idx];
    assign stat.seen_bad    = seen_reg && (last_bad_reg >= item_reg.since_ms);
    assign stat.pend_over   = pend_reg && busy_reg[pend_idx_reg] && over;
    assign stat.pend_last   = pend_reg && (pend_idx_reg == IDXW'(SLOTS - 1));
    assign stat.out_free    = out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.claim |-> !busy_reg[idx_reg])
        else $error("claim of a busy slot");

    a_claim_sets: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.claim |=> busy_reg[$past(idx_reg)])
        else $error("claimed slot not marked busy");

    a_late_records: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.complete && over) |=> seen_reg && last_bad_reg == $past(item_reg.now_ms))
        else $error("late completion not recorded");

endmodule

[rtl/core/ctm_ctrl.sv]
// ----------------------------------------------------------------------------
// ctm_ctrl: sequencer of the call timeout monitor
// Takes one item at a time, walks the slot table as the request needs
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module ctm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ctm_pkg::ctm_stat_t stat,
    output ctm_pkg::ctm_cmd_t  cmd
);

    import ctm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_RSCAN = 3'd2;
    localparam logic [2:0] S_CCHK  = 3'd3;
    localparam logic [2:0] S_QSCAN = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    cmd.idx_clr   = 1'b1;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.req)
                    REQ_REGISTER:
                    begin
                        state_next = S_RSCAN;
                    end
                    REQ_COMPLETE:
                    begin
                        if (!stat.slot_ok)
                        begin
                            cmd.bad_slot = 1'b1;
                            state_next   = S_OUT;
                        end
                        else
                        begin
                            cmd.rd_en       = 1'b1;
                            cmd.rd_sel_slot = 1'b1;
                            state_next      = S_CCHK;
                        end
                    end
                    REQ_QUERY:
                    begin
                        if (stat.seen_bad)
                        begin
                            cmd.q_result = 1'b1;
                            state_next   = S_OUT;
                        end
                        else
                        begin
                            state_next = S_QSCAN;
                        end
                    end
                    default:
                    begin
                        cmd.zero   = 1'b1;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_RSCAN:
            begin
                // advance to the lowest free slot
                if (stat.free_at_idx)
                begin
                    cmd.claim  = 1'b1;
                    state_next = S_OUT;
                end
                else if (stat.idx_last)
                begin
                    cmd.full   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_CCHK:
            begin
                cmd.complete = 1'b1;
                state_next   = S_OUT;
            end
            S_QSCAN:
            begin
                // check the slot read last cycle while the next is read
                if (stat.pend_over)
                begin
                    cmd.q_result = 1'b1;
                    state_next   = S_OUT;
                end
                else if (stat.pend_last)
                begin
                    cmd.q_result  = 1'b1;
                    cmd.q_healthy = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.idx_inc = !stat.idx_last;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> stat.out_free)
        else $error("result pushed over a waiting item");

    a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == S_DISP)
        else $error("accepted item not dispatched");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QSCAN && stat.pend_last) |=> state_reg == S_OUT)
        else $error("query scan ran past the last slot");

endmodule
